// File: rtl/core/nand_large_page_op_sequencer_macros.svh
// Assertion macros used by the NAND large-page sequencer RTL.
`ifndef NAND_LARGE_PAGE_OP_SEQUENCER_MACROS_SVH
`define NAND_LARGE_PAGE_OP_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
`define NLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("NLP assertion failed");
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("NLP assertion failed");
`define NLP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("NLP assertion failed");
`else
`define NLP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define NLP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define NLP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/nlp_pkg.sv
// Types, codes and constants of the NAND large-page operation sequencer.
`default_nettype none
package nlp_pkg;

    localparam int PAGES_PER_BLOCK = 64;
    localparam int PAGE_BYTES      = 2048;
    localparam int SPARE_COLUMN    = 2048;
    localparam int PAGE_WORDS      = PAGE_BYTES / 4;
    localparam int WC_W            = $clog2(PAGE_WORDS);
    localparam int ROW_W           = 24;

    localparam logic [7:0] SPARE_COL_LO = 8'(SPARE_COLUMN);
    localparam logic [7:0] SPARE_COL_HI = 8'(SPARE_COLUMN >> 8);

    localparam logic [2:0] MODE_READ       = 3'd0;
    localparam logic [2:0] MODE_PROG_START = 3'd1;
    localparam logic [2:0] MODE_HOST_WORD  = 3'd2;
    localparam logic [2:0] MODE_ERASE      = 3'd3;
    localparam logic [2:0] MODE_CHECK_BAD  = 3'd4;
    localparam logic [2:0] MODE_MARK_BAD   = 3'd5;
    localparam logic [2:0] MODE_FLASH_BYTE = 3'd6;
    localparam logic [2:0] MODE_READ_ID    = 3'd7;

    localparam logic [2:0] KIND_CMD    = 3'd0;
    localparam logic [2:0] KIND_ADDR   = 3'd1;
    localparam logic [2:0] KIND_DATA   = 3'd2;
    localparam logic [2:0] KIND_WORD   = 3'd3;
    localparam logic [2:0] KIND_STATUS = 3'd4;

    localparam logic [7:0] CMD_READ0     = 8'h00;
    localparam logic [7:0] CMD_READ1     = 8'h30;
    localparam logic [7:0] CMD_PROG0     = 8'h80;
    localparam logic [7:0] CMD_PROG1     = 8'h10;
    localparam logic [7:0] CMD_STATUS    = 8'h70;
    localparam logic [7:0] CMD_ERASE0    = 8'h60;
    localparam logic [7:0] CMD_ERASE1    = 8'hD0;
    localparam logic [7:0] CMD_READ_ID   = 8'h90;
    localparam logic [7:0] GOOD_MARK     = 8'hFF;
    localparam logic [7:0] BAD_MARK      = 8'h00;
    localparam logic [7:0] ZERO_ADDR     = 8'h00;

    typedef enum logic [9:0] {
        PH_IDLE          = 10'b00_0000_0001,
        PH_READ          = 10'b00_0000_0010,
        PH_PROG          = 10'b00_0000_0100,
        PH_PROG_ST       = 10'b00_0000_1000,
        PH_ERASE_ST      = 10'b00_0001_0000,
        PH_ERASE_MARK_ST = 10'b00_0010_0000,
        PH_BAD_CHECK     = 10'b00_0100_0000,
        PH_MARK_ST       = 10'b00_1000_0000,
        PH_ID_FIRST      = 10'b01_0000_0000,
        PH_ID_SECOND     = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [3:0] {
        SEQ_READ,
        SEQ_PROG,
        SEQ_DATA,
        SEQ_ERASE,
        SEQ_CHECK,
        SEQ_MARK,
        SEQ_ID,
        SEQ_WORD,
        SEQ_STATUS
    } t_seq;

    typedef struct packed {
        t_seq              seq;
        logic [ROW_W-1:0]  row;
        logic [31:0]       word;
        logic              status;
        logic              fin;
        logic [3:0]        cnt;
    } t_desc;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] block_index;
        logic [5:0]  page_index;
        logic [31:0] host_word;
        logic [7:0]  flash_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  bus_byte;
        logic [31:0] word_out;
        logic        status;
        logic        last;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/core/nlp_if.sv
// Request and result channel interfaces of the NAND large-page sequencer.
`default_nettype none
interface nlp_req_if;
    import nlp_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface nlp_res_if;
    import nlp_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/nand_large_page_op_sequencer.sv
// Large-page NAND operation sequencer: turns requests into bus cycles and results.
//
// Requests arrive on i_req: read page, program start, host word, erase, check bad,
// mark bad, flash byte and read id. Each accepted beat is decoded in the cycle it
// is taken, the operation state is updated at once, and a compact description of
// the results it causes (none to nine) is stored. Results leave on o_res one per
// beat: command, address and data cycles, words packed from flash bytes and status.
// Its description goes to the active register, or to the holding register while the
// output is busy. A request causing n results occupies the output for n beats; the
// holding register lets the next request be taken while the current one drains, so
// the output runs back to back at one result per cycle while the receiver is ready.
// Requests causing no result are taken every cycle while the holding register is free.
// When the receiver stalls, the current result holds, one further request is
// buffered and i_req.ready then falls. Reset clears the operation phase, the word
// counter, the byte gathering, the result index and both description valid flags.
`default_nettype none
module nand_large_page_op_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nlp_req_if.sink    i_req,
    nlp_res_if.source  o_res
);
    import nlp_pkg::*;
    `include "nand_large_page_op_sequencer_macros.svh"

    t_phase           r_phase, n_phase;
    logic [WC_W-1:0]  r_wc, n_wc;
    logic [23:0]      r_gather, n_gather;
    logic [1:0]       r_pos, n_pos;
    t_desc            r_act, r_pnd, n_desc;
    logic             r_act_v, r_pnd_v;
    logic [3:0]       r_idx;
    logic             in_acc, has_res, out_acc, act_done, act_free;
    logic [ROW_W-1:0] row_page, row_block;

    function automatic t_res res_at(input t_desc d, input logic [3:0] idx);
        t_res r;
        logic [7:0] rb;
        r = '0;
        case (idx)
            4'd3:    rb = d.row[7:0];
            4'd4:    rb = d.row[15:8];
            default: rb = d.row[23:16];
        endcase
        case (d.seq)
            SEQ_READ, SEQ_PROG, SEQ_CHECK, SEQ_MARK: begin
                case (idx)
                    4'd0: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = (d.seq == SEQ_READ || d.seq == SEQ_CHECK)
                                   ? CMD_READ0 : CMD_PROG0;
                    end
                    4'd1: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = (d.seq == SEQ_CHECK || d.seq == SEQ_MARK)
                                   ? SPARE_COL_LO : ZERO_ADDR;
                    end
                    4'd2: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = (d.seq == SEQ_CHECK || d.seq == SEQ_MARK)
                                   ? SPARE_COL_HI : ZERO_ADDR;
                    end
                    4'd3, 4'd4, 4'd5: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = rb;
                    end
                    4'd6: begin
                        r.kind = (d.seq == SEQ_MARK) ? KIND_DATA : KIND_CMD;
                        r.bus_byte = (d.seq == SEQ_MARK) ? BAD_MARK : CMD_READ1;
                    end
                    4'd7: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_PROG1;
                    end
                    default: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_STATUS;
                    end
                endcase
            end
            SEQ_DATA: begin
                case (idx)
                    4'd0: begin
                        r.kind = KIND_DATA;
                        r.bus_byte = d.word[7:0];
                    end
                    4'd1: begin
                        r.kind = KIND_DATA;
                        r.bus_byte = d.word[15:8];
                    end
                    4'd2: begin
                        r.kind = KIND_DATA;
                        r.bus_byte = d.word[23:16];
                    end
                    4'd3: begin
                        r.kind = KIND_DATA;
                        r.bus_byte = d.word[31:24];
                    end
                    4'd4: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_PROG1;
                    end
                    default: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_STATUS;
                    end
                endcase
            end
            SEQ_ERASE: begin
                case (idx)
                    4'd0: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_ERASE0;
                    end
                    4'd1: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = d.row[7:0];
                    end
                    4'd2: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = d.row[15:8];
                    end
                    4'd3: begin
                        r.kind = KIND_ADDR;
                        r.bus_byte = d.row[23:16];
                    end
                    4'd4: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_ERASE1;
                    end
                    default: begin
                        r.kind = KIND_CMD;
                        r.bus_byte = CMD_STATUS;
                    end
                endcase
            end
            SEQ_ID: begin
                if (idx == 4'd0) begin
                    r.kind = KIND_CMD;
                    r.bus_byte = CMD_READ_ID;
                end else begin
                    r.kind = KIND_ADDR;
                    r.bus_byte = ZERO_ADDR;
                end
            end
            SEQ_WORD: begin
                r.kind = KIND_WORD;
                r.word_out = d.word;
            end
            default: begin
                r.kind = KIND_STATUS;
                r.status = d.status;
            end
        endcase
        r.last = (idx == d.cnt - 4'd1) ? d.fin : 1'b0;
        return r;
    endfunction

    assign row_page  = ROW_W'(({8'd0, i_req.data.block_index} * ROW_W'(PAGES_PER_BLOCK))
                       + ROW_W'(i_req.data.page_index));
    assign row_block = ROW_W'({8'd0, i_req.data.block_index} * ROW_W'(PAGES_PER_BLOCK));

    assign i_req.ready = !r_pnd_v;
    assign in_acc      = i_req.valid && i_req.ready;
    assign o_res.valid = r_act_v;
    assign o_res.data  = res_at(r_act, r_idx);
    assign out_acc     = r_act_v && o_res.ready;
    assign act_done    = out_acc && (r_idx == r_act.cnt - 4'd1);
    assign act_free    = !r_act_v || act_done;
    assign has_res     = in_acc && (n_desc.cnt != 4'd0);

    always_comb begin
        n_phase  = r_phase;
        n_wc     = r_wc;
        n_gather = r_gather;
        n_pos    = r_pos;
        n_desc   = '{seq: SEQ_STATUS, row: row_block, word: i_req.data.host_word,
                     status: 1'b0, fin: 1'b1, cnt: 4'd0};
        if (i_req.data.mode != MODE_HOST_WORD && i_req.data.mode != MODE_FLASH_BYTE) begin
            n_wc     = '0;
            n_gather = '0;
            n_pos    = '0;
        end
        case (i_req.data.mode)
            MODE_READ: begin
                n_desc.seq = SEQ_READ;
                n_desc.row = row_page;
                n_desc.cnt = 4'd7;
                n_phase    = PH_READ;
            end
            MODE_PROG_START: begin
                n_desc.seq = SEQ_PROG;
                n_desc.row = row_page;
                n_desc.cnt = 4'd6;
                n_phase    = PH_PROG;
            end
            MODE_HOST_WORD: begin
                if (r_phase == PH_PROG) begin
                    n_desc.seq = SEQ_DATA;
                    if (r_wc == WC_W'(PAGE_WORDS - 1)) begin
                        n_desc.cnt = 4'd6;
                        n_wc       = '0;
                        n_phase    = PH_PROG_ST;
                    end else begin
                        n_desc.cnt = 4'd4;
                        n_wc       = r_wc + 1'b1;
                    end
                end
            end
            MODE_ERASE: begin
                n_desc.seq = SEQ_ERASE;
                n_desc.cnt = 4'd6;
                n_phase    = PH_ERASE_ST;
            end
            MODE_CHECK_BAD: begin
                n_desc.seq = SEQ_CHECK;
                n_desc.cnt = 4'd7;
                n_phase    = PH_BAD_CHECK;
            end
            MODE_MARK_BAD: begin
                n_desc.seq = SEQ_MARK;
                n_desc.cnt = 4'd9;
                n_phase    = PH_MARK_ST;
            end
            MODE_READ_ID: begin
                n_desc.seq = SEQ_ID;
                n_desc.cnt = 4'd2;
                n_phase    = PH_ID_FIRST;
            end
            MODE_FLASH_BYTE: begin
                case (r_phase)
                    PH_READ: begin
                        case (r_pos)
                            2'd0: n_gather[7:0]   = i_req.data.flash_byte;
                            2'd1: n_gather[15:8]  = i_req.data.flash_byte;
                            2'd2: n_gather[23:16] = i_req.data.flash_byte;
                            default: begin
                                n_desc.seq  = SEQ_WORD;
                                n_desc.word = {i_req.data.flash_byte, r_gather};
                                n_desc.cnt  = 4'd1;
                                n_gather    = '0;
                                if (r_wc == WC_W'(PAGE_WORDS - 1)) begin
                                    n_wc    = '0;
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_desc.fin = 1'b0;
                                    n_wc       = r_wc + 1'b1;
                                end
                            end
                        endcase
                        n_pos = r_pos + 2'd1;
                    end
                    PH_PROG_ST, PH_MARK_ST: begin
                        n_desc.status = i_req.data.flash_byte[0];
                        n_desc.cnt    = 4'd1;
                        n_phase       = PH_IDLE;
                    end
                    PH_ERASE_ST: begin
                        if (i_req.data.flash_byte[0]) begin
                            n_desc.seq = SEQ_MARK;
                            n_desc.cnt = 4'd9;
                            n_phase    = PH_ERASE_MARK_ST;
                        end else begin
                            n_desc.cnt = 4'd1;
                            n_phase    = PH_IDLE;
                        end
                    end
                    PH_ERASE_MARK_ST: begin
                        n_desc.status = 1'b1;
                        n_desc.cnt    = 4'd1;
                        n_phase       = PH_IDLE;
                    end
                    PH_BAD_CHECK: begin
                        n_desc.status = (i_req.data.flash_byte != GOOD_MARK);
                        n_desc.cnt    = 4'd1;
                        n_phase       = PH_IDLE;
                    end
                    PH_ID_FIRST: begin
                        n_gather = {16'd0, i_req.data.flash_byte};
                        n_phase  = PH_ID_SECOND;
                    end
                    PH_ID_SECOND: begin
                        n_desc.seq  = SEQ_WORD;
                        n_desc.word = {8'd0, i_req.data.flash_byte, 8'd0, r_gather[7:0]};
                        n_desc.cnt  = 4'd1;
                        n_gather    = '0;
                        n_phase     = PH_IDLE;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_wc     <= '0;
            r_gather <= '0;
            r_pos    <= '0;
            r_act_v  <= 1'b0;
            r_pnd_v  <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (in_acc) begin
                r_phase  <= n_phase;
                r_wc     <= n_wc;
                r_gather <= n_gather;
                r_pos    <= n_pos;
            end
            if (act_free) begin
                r_idx <= '0;
                if (r_pnd_v) begin
                    r_act_v <= 1'b1;
                    r_pnd_v <= has_res;
                end else begin
                    r_act_v <= has_res;
                end
            end else begin
                if (out_acc) begin
                    r_idx <= r_idx + 4'd1;
                end
                if (has_res) begin
                    r_pnd_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_free) begin
            if (r_pnd_v) begin
                r_act <= r_pnd;
                r_pnd <= n_desc;
            end else begin
                r_act <= n_desc;
            end
        end else if (has_res) begin
            r_pnd <= n_desc;
        end
    end

    `NLP_ASSERT_IMPLIES(a_pnd_needs_act, i_clk, i_rst_n, r_pnd_v, r_act_v)
    `NLP_ASSERT_IMPLIES(a_idx_in_range, i_clk, i_rst_n, r_act_v,
                        (r_act.cnt != 4'd0) && (r_idx < r_act.cnt))
    `NLP_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, out_acc && !act_done,
                     o_res.valid && (r_idx == $past(r_idx) + 4'd1))
    `NLP_ASSERT_ALWAYS(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase))
    `NLP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_res.valid && !o_res.ready,
                     o_res.valid && $stable(r_idx))

endmodule
`default_nettype wire

// File: test/nlp_sequence_checker.sv
// Checker for the NAND large-page sequencer: predicts result beats and compares them.
`timescale 1ns / 1ps
module nlp_sequence_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  nlp_pkg::t_req i_req_data,
    input  logic          i_res_valid,
    input  logic          i_res_ready,
    input  nlp_pkg::t_res i_res_data,
    output int            o_outstanding,
    output int            o_errors,
    output int            o_checked
);
    import nlp_pkg::*;

    t_phase      seq_phase;
    int          word_count;
    logic [23:0] byte_gather;
    int          byte_position;
    t_res        expected_beats[$];
    t_res        step_beats[$];
    t_res        want;
    t_res        got;
    int          errors;
    int          checked;

    initial begin
        o_outstanding = 0;
        o_errors      = 0;
        o_checked     = 0;
        errors        = 0;
        checked       = 0;
        seq_phase     = PH_IDLE;
        word_count    = 0;
        byte_gather   = '0;
        byte_position = 0;
    end

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, seen,
                 wanted);
        errors++;
    endtask

    function automatic void put(logic [2:0] kind, logic [7:0] bus, logic [31:0] word,
                                logic st);
        t_res r;
        r.kind     = kind;
        r.bus_byte = bus;
        r.word_out = word;
        r.status   = st;
        r.last     = 1'b0;
        step_beats.push_back(r);
    endfunction

    function automatic logic [23:0] row_of(logic [15:0] blk, logic [5:0] pg);
        logic [31:0] full;
        full = 32'(blk) * 32'(PAGES_PER_BLOCK) + 32'(pg);
        return full[23:0];
    endfunction

    function automatic void put_row(logic [23:0] row);
        put(KIND_ADDR, row[7:0], 32'd0, 1'b0);
        put(KIND_ADDR, row[15:8], 32'd0, 1'b0);
        put(KIND_ADDR, row[23:16], 32'd0, 1'b0);
    endfunction

    function automatic void put_mark(logic [15:0] blk);
        put(KIND_CMD, CMD_PROG0, 32'd0, 1'b0);
        put(KIND_ADDR, SPARE_COL_LO, 32'd0, 1'b0);
        put(KIND_ADDR, SPARE_COL_HI, 32'd0, 1'b0);
        put_row(row_of(blk, 6'd0));
        put(KIND_DATA, BAD_MARK, 32'd0, 1'b0);
        put(KIND_CMD, CMD_PROG1, 32'd0, 1'b0);
        put(KIND_CMD, CMD_STATUS, 32'd0, 1'b0);
    endfunction

    task automatic sequence_request(t_req rq);
        bit          last_on_final;
        logic [31:0] packed_word;
        logic        fin;
        step_beats.delete();
        last_on_final = 1'b1;
        if (rq.mode != MODE_HOST_WORD && rq.mode != MODE_FLASH_BYTE) begin
            word_count    = 0;
            byte_gather   = '0;
            byte_position = 0;
        end
        case (rq.mode)
            MODE_READ: begin
                put(KIND_CMD, CMD_READ0, 32'd0, 1'b0);
                put(KIND_ADDR, ZERO_ADDR, 32'd0, 1'b0);
                put(KIND_ADDR, ZERO_ADDR, 32'd0, 1'b0);
                put_row(row_of(rq.block_index, rq.page_index));
                put(KIND_CMD, CMD_READ1, 32'd0, 1'b0);
                seq_phase = PH_READ;
            end
            MODE_PROG_START: begin
                put(KIND_CMD, CMD_PROG0, 32'd0, 1'b0);
                put(KIND_ADDR, ZERO_ADDR, 32'd0, 1'b0);
                put(KIND_ADDR, ZERO_ADDR, 32'd0, 1'b0);
                put_row(row_of(rq.block_index, rq.page_index));
                seq_phase = PH_PROG;
            end
            MODE_HOST_WORD: begin
                if (seq_phase == PH_PROG) begin
                    put(KIND_DATA, rq.host_word[7:0], 32'd0, 1'b0);
                    put(KIND_DATA, rq.host_word[15:8], 32'd0, 1'b0);
                    put(KIND_DATA, rq.host_word[23:16], 32'd0, 1'b0);
                    put(KIND_DATA, rq.host_word[31:24], 32'd0, 1'b0);
                    word_count++;
                    if (word_count >= PAGE_WORDS) begin
                        put(KIND_CMD, CMD_PROG1, 32'd0, 1'b0);
                        put(KIND_CMD, CMD_STATUS, 32'd0, 1'b0);
                        word_count = 0;
                        seq_phase  = PH_PROG_ST;
                    end
                end
            end
            MODE_ERASE: begin
                put(KIND_CMD, CMD_ERASE0, 32'd0, 1'b0);
                put_row(row_of(rq.block_index, 6'd0));
                put(KIND_CMD, CMD_ERASE1, 32'd0, 1'b0);
                put(KIND_CMD, CMD_STATUS, 32'd0, 1'b0);
                seq_phase = PH_ERASE_ST;
            end
            MODE_CHECK_BAD: begin
                put(KIND_CMD, CMD_READ0, 32'd0, 1'b0);
                put(KIND_ADDR, SPARE_COL_LO, 32'd0, 1'b0);
                put(KIND_ADDR, SPARE_COL_HI, 32'd0, 1'b0);
                put_row(row_of(rq.block_index, 6'd0));
                put(KIND_CMD, CMD_READ1, 32'd0, 1'b0);
                seq_phase = PH_BAD_CHECK;
            end
            MODE_MARK_BAD: begin
                put_mark(rq.block_index);
                seq_phase = PH_MARK_ST;
            end
            MODE_READ_ID: begin
                put(KIND_CMD, CMD_READ_ID, 32'd0, 1'b0);
                put(KIND_ADDR, ZERO_ADDR, 32'd0, 1'b0);
                seq_phase = PH_ID_FIRST;
            end
            default: begin
                case (seq_phase)
                    PH_READ: begin
                        if (byte_position < 3) begin
                            byte_gather = byte_gather | (24'(rq.flash_byte) << (8 * byte_position));
                            byte_position++;
                        end else begin
                            packed_word   = {rq.flash_byte, byte_gather};
                            byte_gather   = '0;
                            byte_position = 0;
                            word_count++;
                            fin = (word_count >= PAGE_WORDS);
                            put(KIND_WORD, 8'd0, packed_word, 1'b0);
                            step_beats[step_beats.size() - 1].last = fin;
                            last_on_final = 1'b0;
                            if (fin) begin
                                word_count = 0;
                                seq_phase  = PH_IDLE;
                            end
                        end
                    end
                    PH_PROG_ST, PH_MARK_ST: begin
                        put(KIND_STATUS, 8'd0, 32'd0, rq.flash_byte[0]);
                        seq_phase = PH_IDLE;
                    end
                    PH_ERASE_ST: begin
                        if (rq.flash_byte[0]) begin
                            put_mark(rq.block_index);
                            seq_phase = PH_ERASE_MARK_ST;
                        end else begin
                            put(KIND_STATUS, 8'd0, 32'd0, 1'b0);
                            seq_phase = PH_IDLE;
                        end
                    end
                    PH_ERASE_MARK_ST: begin
                        put(KIND_STATUS, 8'd0, 32'd0, 1'b1);
                        seq_phase = PH_IDLE;
                    end
                    PH_BAD_CHECK: begin
                        put(KIND_STATUS, 8'd0, 32'd0, rq.flash_byte != GOOD_MARK);
                        seq_phase = PH_IDLE;
                    end
                    PH_ID_FIRST: begin
                        byte_gather = 24'(rq.flash_byte);
                        seq_phase   = PH_ID_SECOND;
                    end
                    PH_ID_SECOND: begin
                        put(KIND_WORD, 8'd0, {8'd0, rq.flash_byte, 8'd0, byte_gather[7:0]}, 1'b0);
                        byte_gather = '0;
                        seq_phase   = PH_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        if (last_on_final && step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].last = 1'b1;
        end
        foreach (step_beats[i]) begin
            expected_beats.push_back(step_beats[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_phase     = PH_IDLE;
            word_count    = 0;
            byte_gather   = '0;
            byte_position = 0;
            expected_beats.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res_data;
                if (expected_beats.size() == 0) begin
                    report_mismatch("result beat with nothing expected", 32'(got.kind), 32'd0);
                end else begin
                    want = expected_beats.pop_front();
                    checked++;
                    if (got.kind !== want.kind) begin
                        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                    end
                    if (got.bus_byte !== want.bus_byte) begin
                        report_mismatch("bus_byte", 32'(got.bus_byte), 32'(want.bus_byte));
                    end
                    if (got.word_out !== want.word_out) begin
                        report_mismatch("word_out", got.word_out, want.word_out);
                    end
                    if (got.status !== want.status) begin
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    end
                    if (got.last !== want.last) begin
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                sequence_request(i_req_data);
            end
        end
        o_outstanding <= expected_beats.size();
        o_errors      <= errors;
        o_checked     <= checked;
    end

endmodule

// File: test/nand_large_page_op_sequencer_tb.sv
// Testbench top for the NAND large-page sequencer: drives requests, stalls results, gives the verdict.
`timescale 1ns / 1ps
module nand_large_page_op_sequencer_tb;
    import nlp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   outstanding;
    int   errors;
    int   checked;
    int   beats_offered;
    int   sequences_run;
    bit   calm;
    bit   want_hold;

    nlp_req_if req_ch();
    nlp_res_if res_ch();

    nand_large_page_op_sequencer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    nlp_sequence_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_ch.valid),
        .i_req_ready   (req_ch.ready),
        .i_req_data    (req_ch.data),
        .i_res_valid   (res_ch.valid),
        .i_res_ready   (res_ch.ready),
        .i_res_data    (res_ch.data),
        .o_outstanding (outstanding),
        .o_errors      (errors),
        .o_checked     (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic offer(logic [2:0] mode, logic [15:0] blk, logic [5:0] pg,
                         logic [31:0] hw, logic [7:0] fb);
        int   gap;
        t_req rq;
        rq.mode        = mode;
        rq.block_index = blk;
        rq.page_index  = pg;
        rq.host_word   = hw;
        rq.flash_byte  = fb;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        beats_offered++;
    endtask

    task automatic offer_random(logic [2:0] mode);
        offer(mode, 16'($urandom), 6'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic offer_byte(logic [7:0] fb);
        offer(MODE_FLASH_BYTE, 16'($urandom), 6'($urandom), $urandom, fb);
    endtask

    initial begin
        int slow;
        int stall_left;
        res_ch.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (want_hold) begin
                want_hold = 1'b0;
                slow = 400;
                res_ch.ready <= 1'b0;
                while (slow > 0) begin
                    @(posedge i_clk);
                    slow--;
                end
            end else if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 99) < 25) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin
        int          choice;
        int          n;
        logic [7:0]  fb;
        beats_offered = 0;
        sequences_run = 0;
        calm          = 1'b0;
        want_hold     = 1'b0;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'hA5);
        offer(MODE_HOST_WORD, 16'hFFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        offer(MODE_READ_ID, 16'hFFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        offer(MODE_FLASH_BYTE, 16'hFFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_READ, 16'hFFFF, 6'd63, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'hFF);
        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'h5A);
        offer(MODE_FLASH_BYTE, 16'h0000, 6'd0, 32'h0000_0000, 8'hC3);
        offer(MODE_PROG_START, 16'h0000, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_HOST_WORD, 16'h0000, 6'd0, 32'hFFFF_FFFF, 8'h00);
        offer(MODE_HOST_WORD, 16'h0000, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_ERASE, 16'h8001, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h8001, 6'd0, 32'h0000_0000, 8'hFE);
        offer(MODE_ERASE, 16'hFFFF, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'hFFFF, 6'd0, 32'h0000_0000, 8'h01);
        offer(MODE_FLASH_BYTE, 16'hFFFF, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_CHECK_BAD, 16'h0001, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h0001, 6'd0, 32'h0000_0000, GOOD_MARK);
        offer(MODE_CHECK_BAD, 16'h0002, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h0002, 6'd0, 32'h0000_0000, BAD_MARK);
        offer(MODE_MARK_BAD, 16'h7FFF, 6'd0, 32'h0000_0000, 8'h00);
        offer(MODE_FLASH_BYTE, 16'h7FFF, 6'd0, 32'h0000_0000, 8'h01);

        for (int s = 0; s < 64; s++) begin
            calm = ($urandom_range(0, 9) == 0);
            choice = $urandom_range(0, 9);
            if (s == 30) choice = 2;
            if (s == 30) want_hold = 1'b1;
            case (choice)
                0, 1: begin
                    n = $urandom_range(0, 13);
                    offer_random(MODE_READ);
                    repeat (n) offer_random(MODE_FLASH_BYTE);
                end
                2, 3: begin
                    n = (s == 30) ? 12 : $urandom_range(0, 6);
                    offer_random(MODE_PROG_START);
                    repeat (n) offer_random(MODE_HOST_WORD);
                end
                4: begin
                    offer_random(MODE_ERASE);
                    fb = 8'($urandom);
                    offer_byte(fb);
                    if (fb[0]) offer_random(MODE_FLASH_BYTE);
                end
                5: begin
                    offer_random(MODE_CHECK_BAD);
                    offer_byte($urandom_range(0, 1) ? GOOD_MARK : 8'($urandom));
                end
                6: begin
                    offer_random(MODE_MARK_BAD);
                    offer_random(MODE_FLASH_BYTE);
                end
                7: begin
                    offer_random(MODE_READ_ID);
                    repeat (2) offer_random(MODE_FLASH_BYTE);
                end
                default: begin
                    repeat ($urandom_range(1, 4)) offer_random(3'($urandom_range(0, 7)));
                end
            endcase
            sequences_run++;
        end

        req_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Run offered %0d request beats in %0d random sequences; %0d result beats checked.",
                 beats_offered, sequences_run, checked);
        $display("%s %s", "It took in partial page reads and programs, failed erases with",
                 "bad-block marks, abandoned operations and a long receiver hold-off.");
        if (errors == 0) begin
            $display("** nand_large_page_op_sequencer: PASSED **");
        end else begin
            $display("** nand_large_page_op_sequencer: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Run stopped after the time limit with %0d result beats outstanding.",
                 outstanding);
        $display("** nand_large_page_op_sequencer: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/nlp_pkg.sv
rtl/core/nlp_if.sv
rtl/core/nand_large_page_op_sequencer.sv
test/nlp_sequence_checker.sv
test/nand_large_page_op_sequencer_tb.sv
